// ===== src/mjos_pkg.sv =====
// ----------------------------------------------------------------------------
// mjos_pkg: shared constants for the minimum-jitter offset search
// Defaults for parameters and fixed values of the search.
// ----------------------------------------------------------------------------
package mjos_pkg;

    localparam int MAX_SLOTS_DEF  = 256;
    localparam int FRAME_RESET    = 150;
    localparam int START_JITTER   = 100000;
    localparam int OFFSET_LIMIT   = 256;
    localparam int PERIOD_W       = 9;
    localparam int OFFSET_W       = 8;
    localparam int JITTER_OUT_W   = 18;

endpackage

// ===== src/min_jitter_offset_search_top.sv =====
// ----------------------------------------------------------------------------
// min_jitter_offset_search_top: static cyclic schedule offset search
// Throughput: one word at a time; in_ready is high only while idle.
// One shared walker reads both slot tables at one address, each through a registered read port.
// Reset: control and frame_cfg (150) reset; slot tables are swept per trial.
// ----------------------------------------------------------------------------
module min_jitter_offset_search_top #(
    parameter int MAX_SLOTS = mjos_pkg::MAX_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mjos_pkg::PERIOD_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mjos_pkg::PERIOD_W-1:0]       period_a,
    input  logic [mjos_pkg::PERIOD_W-1:0]       period_b,
    input  logic [mjos_pkg::PERIOD_W-1:0]       period_c,
    input  logic [mjos_pkg::PERIOD_W-1:0]       period_d,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mjos_pkg::JITTER_OUT_W-1:0]   min_jitter,
    output logic [mjos_pkg::OFFSET_W-1:0]       best_offset_b,
    output logic [mjos_pkg::OFFSET_W-1:0]       best_offset_c,
    output logic [mjos_pkg::OFFSET_W-1:0]       best_offset_d
);

    localparam int PW = mjos_pkg::PERIOD_W;
    localparam int OW = mjos_pkg::OFFSET_W;
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int FW = $clog2(MAX_SLOTS + 1);
    localparam int IW = $clog2(MAX_SLOTS + (1 << PW));
    localparam int JBOUND = 3 * MAX_SLOTS * MAX_SLOTS;
    localparam int JW = ($clog2(JBOUND + 1) > mjos_pkg::JITTER_OUT_W) ?
                        $clog2(JBOUND + 1) : mjos_pkg::JITTER_OUT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BUILD  = 3'd1;
    localparam logic [2:0] S_CLRD   = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [1:0] TASK_B = 2'd0;
    localparam logic [1:0] TASK_C = 2'd1;
    localparam logic [1:0] TASK_D = 2'd2;

    localparam logic [PW-1:0] OFF_LIMIT = PW'(mjos_pkg::OFFSET_LIMIT);

    // control
    logic [2:0]    state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] frame_cfg_reg, frame_cfg_next;

    // datapath
    logic [PW-1:0] pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next, pd_reg, pd_next;
    logic [PW-1:0] nb_reg, nb_next, nc_reg, nc_next, nd_reg, nd_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic [PW-1:0] j_reg, j_next, k_reg, k_next, l_reg, l_next;
    logic [FW-1:0] c_reg, c_next;
    logic [IW-1:0] a_pos_reg, a_pos_next;
    logic          a_live_reg, a_live_next;
    logic [1:0]    task_reg, task_next;
    logic [IW-1:0] i_reg, i_next, t_reg, t_next;
    logic [JW-1:0] jit_reg, jit_next, base_reg, base_next, best_reg, best_next;
    logic [OW-1:0] bj_reg, bj_next, bk_reg, bk_next, bl_reg, bl_next;
    logic [mjos_pkg::JITTER_OUT_W-1:0] res_jit_reg, res_jit_next;
    logic [OW-1:0] res_b_reg, res_b_next, res_c_reg, res_c_next, res_d_reg, res_d_next;

    // slot tables: A/B/C marks and D marks
    logic          abc_mem [MAX_SLOTS];
    logic          d_mem   [MAX_SLOTS];
    logic          abc_q, d_q;
    logic          abc_we, abc_wd, d_we, d_wd;
    logic [AW-1:0] wr_addr, rd_addr;

    function automatic logic more_offsets(input logic [PW-1:0] cur, input logic [PW-1:0] n,
                                          input logic [FW-1:0] fr);
        logic [IW-1:0] nxt;
        nxt = IW'(cur) + IW'(1);
        return (nxt < IW'(n)) && (nxt <= IW'(fr));
    endfunction

    function automatic logic [PW-1:0] cap_offsets(input logic [PW-1:0] p);
        return (p > OFF_LIMIT) ? OFF_LIMIT : p;
    endfunction

    logic [IW-1:0] frame_ext;
    logic [IW-1:0] c_ext;
    logic [IW-1:0] period;
    logic          a_hit;
    logic          busy;

    assign frame_ext = IW'(frame_reg);
    assign c_ext     = IW'(c_reg);
    assign a_hit     = a_live_reg && (c_ext == a_pos_reg);
    assign busy      = abc_q || ((task_reg == TASK_D) && d_q);
    assign rd_addr   = t_reg[AW-1:0];

    always_comb
    begin
        case (task_reg)
            TASK_B:  period = IW'(pb_reg);
            TASK_C:  period = IW'(pc_reg);
            default: period = IW'(pd_reg);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        frame_cfg_next = frame_cfg_reg;
        pa_next = pa_reg;  pb_next = pb_reg;  pc_next = pc_reg;  pd_next = pd_reg;
        nb_next = nb_reg;  nc_next = nc_reg;  nd_next = nd_reg;
        frame_next  = frame_reg;
        j_next = j_reg;  k_next = k_reg;  l_next = l_reg;
        c_next      = c_reg;
        a_pos_next  = a_pos_reg;
        a_live_next = a_live_reg;
        task_next   = task_reg;
        i_next = i_reg;  t_next = t_reg;
        jit_next = jit_reg;  base_next = base_reg;  best_next = best_reg;
        bj_next = bj_reg;  bk_next = bk_reg;  bl_next = bl_reg;
        res_jit_next = res_jit_reg;
        res_b_next = res_b_reg;  res_c_next = res_c_reg;  res_d_next = res_d_reg;
        abc_we  = 1'b0;
        abc_wd  = 1'b0;
        d_we    = 1'b0;
        d_wd    = 1'b0;
        wr_addr = c_reg[AW-1:0];

        if (cfg_we)
        begin
            frame_cfg_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pa_next = period_a;
                    pb_next = period_b;
                    pc_next = period_c;
                    pd_next = period_d;
                    nb_next = cap_offsets(period_b);
                    nc_next = cap_offsets(period_c);
                    nd_next = cap_offsets(period_d);
                    if (int'(frame_cfg_reg) > MAX_SLOTS)
                        frame_next = FW'(MAX_SLOTS);
                    else
                        frame_next = FW'(frame_cfg_reg);
                    j_next      = '0;
                    k_next      = '0;
                    l_next      = '0;
                    c_next      = '0;
                    a_pos_next  = '0;
                    a_live_next = 1'b1;
                    best_next   = JW'(mjos_pkg::START_JITTER);
                    bj_next     = '0;
                    bk_next     = '0;
                    bl_next     = '0;
                    if ((period_b == '0) || (period_c == '0) || (period_d == '0))
                        state_next = S_FINISH;
                    else
                        state_next = S_BUILD;
                end
            end

            S_BUILD:
            begin
                if (c_ext >= frame_ext)
                begin
                    task_next  = TASK_B;
                    i_next     = IW'(j_reg);
                    t_next     = IW'(j_reg);
                    jit_next   = '0;
                    state_next = S_ISSUE;
                end
                else
                begin
                    abc_we  = 1'b1;
                    abc_wd  = a_hit;
                    if (a_hit)
                    begin
                        if (pa_reg == '0)
                            a_live_next = 1'b0;
                        else
                            a_pos_next = a_pos_reg + IW'(pa_reg);
                    end
                    c_next = c_reg + FW'(1);
                end
            end

            S_CLRD:
            begin
                if (c_ext >= frame_ext)
                begin
                    task_next  = TASK_D;
                    i_next     = IW'(l_reg);
                    t_next     = IW'(l_reg);
                    jit_next   = base_reg;
                    state_next = S_ISSUE;
                end
                else
                begin
                    d_we   = 1'b1;
                    d_wd   = 1'b0;
                    c_next = c_reg + FW'(1);
                end
            end

            S_ISSUE:
            begin
                if (i_reg >= frame_ext)
                begin
                    case (task_reg)
                        TASK_B:
                        begin
                            task_next = TASK_C;
                            i_next    = IW'(k_reg);
                            t_next    = IW'(k_reg);
                        end
                        TASK_C:
                        begin
                            base_next  = jit_reg;
                            l_next     = '0;
                            c_next     = '0;
                            state_next = S_CLRD;
                        end
                        default:
                        begin
                            if (jit_reg < best_reg)
                            begin
                                best_next = jit_reg;
                                bj_next   = j_reg[OW-1:0];
                                bk_next   = k_reg[OW-1:0];
                                bl_next   = l_reg[OW-1:0];
                            end
                            c_next      = '0;
                            a_pos_next  = '0;
                            a_live_next = 1'b1;
                            if (more_offsets(l_reg, nd_reg, frame_reg))
                            begin
                                l_next     = l_reg + PW'(1);
                                state_next = S_CLRD;
                            end
                            else if (more_offsets(k_reg, nc_reg, frame_reg))
                            begin
                                k_next     = k_reg + PW'(1);
                                state_next = S_BUILD;
                            end
                            else if (more_offsets(j_reg, nb_reg, frame_reg))
                            begin
                                j_next     = j_reg + PW'(1);
                                k_next     = '0;
                                state_next = S_BUILD;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                    endcase
                end
                else if (t_reg >= frame_ext)
                begin
                    // displaced past frame end: placement dropped
                    i_next = i_reg + period;
                    t_next = i_reg + period;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (busy)
                begin
                    t_next     = t_reg + IW'(1);
                    jit_next   = jit_reg + JW'(1);
                end
                else
                begin
                    wr_addr = t_reg[AW-1:0];
                    if (task_reg == TASK_D)
                    begin
                        d_we = 1'b1;
                        d_wd = 1'b1;
                    end
                    else
                    begin
                        abc_we = 1'b1;
                        abc_wd = 1'b1;
                    end
                    i_next = i_reg + period;
                    t_next = i_reg + period;
                end
                state_next = S_ISSUE;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_jit_next   = best_reg[mjos_pkg::JITTER_OUT_W-1:0];
                    res_b_next     = bj_reg;
                    res_c_next     = bk_reg;
                    res_d_next     = bl_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            frame_cfg_reg <= PW'(mjos_pkg::FRAME_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            frame_cfg_reg <= frame_cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        pc_reg      <= pc_next;
        pd_reg      <= pd_next;
        nb_reg      <= nb_next;
        nc_reg      <= nc_next;
        nd_reg      <= nd_next;
        frame_reg   <= frame_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        l_reg       <= l_next;
        c_reg       <= c_next;
        a_pos_reg   <= a_pos_next;
        a_live_reg  <= a_live_next;
        task_reg    <= task_next;
        i_reg       <= i_next;
        t_reg       <= t_next;
        jit_reg     <= jit_next;
        base_reg    <= base_next;
        best_reg    <= best_next;
        bj_reg      <= bj_next;
        bk_reg      <= bk_next;
        bl_reg      <= bl_next;
        res_jit_reg <= res_jit_next;
        res_b_reg   <= res_b_next;
        res_c_reg   <= res_c_next;
        res_d_reg   <= res_d_next;
    end

    always_ff @(posedge clk)
    begin
        if (abc_we)
        begin
            abc_mem[wr_addr] <= abc_wd;
        end
        abc_q <= abc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            d_mem[wr_addr] <= d_wd;
        end
        d_q <= d_mem[rd_addr];
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign min_jitter    = res_jit_reg;
    assign best_offset_b = res_b_reg;
    assign best_offset_c = res_c_reg;
    assign best_offset_d = res_d_reg;

endmodule

// ===== test/tb_min_jitter_offset_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_jitter_offset_search_top: testbench for the offset search block
// Drives period words under several frame sizes and idle patterns. A
// scoreboard repeats the offset search for every accepted word and checks
// each result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [mjos_pkg::JITTER_OUT_W-1:0] min_jitter;
    logic [mjos_pkg::OFFSET_W-1:0]     offset_b;
    logic [mjos_pkg::OFFSET_W-1:0]     offset_c;
    logic [mjos_pkg::OFFSET_W-1:0]     offset_d;
} schedule_result_t;

class schedule_checker;
    schedule_result_t              pending_schedules[$];
    logic [mjos_pkg::PERIOD_W-1:0] frame_cfg;
    int unsigned                   error_count;
    int unsigned                   probe_count;

    function new();
        frame_cfg   = mjos_pkg::FRAME_RESET[mjos_pkg::PERIOD_W-1:0];
        error_count = 0;
        probe_count = 0;
    endfunction

    function void set_frame(input logic [mjos_pkg::PERIOD_W-1:0] value);
        frame_cfg = value;
    endfunction

    function int pending();
        return pending_schedules.size();
    endfunction

    // one task placed from its offset at its period, walking past busy slots
    function void place_task(inout logic [mjos_pkg::MAX_SLOTS_DEF-1:0] busy,
                             input int unsigned off, input int unsigned period,
                             input int unsigned frame, inout int unsigned jit);
        int unsigned i;
        int unsigned t;
        i = off;
        while (i < frame) begin
            probe_count++;
            if (!busy[i]) begin
                busy[i] = 1'b1;
            end
            else begin
                t = i;
                do begin
                    t++;
                    jit++;
                    if (t < frame)
                        probe_count++;
                end while (t < frame && busy[t]);
                if (t < frame)
                    busy[t] = 1'b1;
            end
            i += period;
        end
    endfunction

    // predicts the search result; returns a rough cycle cost of the search
    function int unsigned note_word(input logic [mjos_pkg::PERIOD_W-1:0] pa,
                                    input logic [mjos_pkg::PERIOD_W-1:0] pb,
                                    input logic [mjos_pkg::PERIOD_W-1:0] pc,
                                    input logic [mjos_pkg::PERIOD_W-1:0] pd);
        int unsigned frame, nb, nc, nd;
        int unsigned j, k, l, i;
        int unsigned base_jit, trial_jit, best_jit;
        int unsigned bj, bk, bl;
        int unsigned cost;
        logic [mjos_pkg::MAX_SLOTS_DEF-1:0] after_bc;
        logic [mjos_pkg::MAX_SLOTS_DEF-1:0] busy;
        schedule_result_t exp_r;
        frame = (frame_cfg > mjos_pkg::MAX_SLOTS_DEF) ? mjos_pkg::MAX_SLOTS_DEF : frame_cfg;
        nb = (pb < mjos_pkg::OFFSET_LIMIT) ? pb : mjos_pkg::OFFSET_LIMIT;
        nc = (pc < mjos_pkg::OFFSET_LIMIT) ? pc : mjos_pkg::OFFSET_LIMIT;
        nd = (pd < mjos_pkg::OFFSET_LIMIT) ? pd : mjos_pkg::OFFSET_LIMIT;
        best_jit = mjos_pkg::START_JITTER;
        bj = 0;
        bk = 0;
        bl = 0;
        cost = 4;
        for (j = 0; j < nb && j <= frame; j++) begin
            for (k = 0; k < nc && k <= frame; k++) begin
                base_jit = 0;
                after_bc = '0;
                if (pa == 0) begin
                    if (frame > 0)
                        after_bc[0] = 1'b1;
                end
                else begin
                    for (i = 0; i < frame; i += pa)
                        after_bc[i] = 1'b1;
                end
                probe_count = 0;
                place_task(after_bc, j, pb, frame, base_jit);
                place_task(after_bc, k, pc, frame, base_jit);
                cost += frame + 4 + 2 * probe_count;
                for (l = 0; l < nd && l <= frame; l++) begin
                    busy = after_bc;
                    trial_jit = base_jit;
                    probe_count = 0;
                    place_task(busy, l, pd, frame, trial_jit);
                    cost += frame + 4 + 2 * probe_count;
                    if (trial_jit < best_jit) begin
                        best_jit = trial_jit;
                        bj = j;
                        bk = k;
                        bl = l;
                    end
                end
            end
        end
        exp_r.min_jitter = best_jit[mjos_pkg::JITTER_OUT_W-1:0];
        exp_r.offset_b   = bj[mjos_pkg::OFFSET_W-1:0];
        exp_r.offset_c   = bk[mjos_pkg::OFFSET_W-1:0];
        exp_r.offset_d   = bl[mjos_pkg::OFFSET_W-1:0];
        pending_schedules.push_back(exp_r);
        return cost;
    endfunction

    function void check_word(input schedule_result_t act);
        schedule_result_t exp_r;
        if (pending_schedules.size() == 0) begin
            $display("%0t: unexpected result word jitter=%0d b=%0d c=%0d d=%0d",
                     $time, act.min_jitter, act.offset_b, act.offset_c, act.offset_d);
            error_count++;
            return;
        end
        exp_r = pending_schedules.pop_front();
        if (act.min_jitter !== exp_r.min_jitter) begin
            $display("%0t: min_jitter expected %0d actual %0d",
                     $time, exp_r.min_jitter, act.min_jitter);
            error_count++;
        end
        if (act.offset_b !== exp_r.offset_b) begin
            $display("%0t: best_offset_b expected %0d actual %0d",
                     $time, exp_r.offset_b, act.offset_b);
            error_count++;
        end
        if (act.offset_c !== exp_r.offset_c) begin
            $display("%0t: best_offset_c expected %0d actual %0d",
                     $time, exp_r.offset_c, act.offset_c);
            error_count++;
        end
        if (act.offset_d !== exp_r.offset_d) begin
            $display("%0t: best_offset_d expected %0d actual %0d",
                     $time, exp_r.offset_d, act.offset_d);
            error_count++;
        end
    endfunction
endclass

module tb_min_jitter_offset_search_top;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [mjos_pkg::PERIOD_W-1:0]       cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [mjos_pkg::PERIOD_W-1:0]       period_a = '0;
    logic [mjos_pkg::PERIOD_W-1:0]       period_b = '0;
    logic [mjos_pkg::PERIOD_W-1:0]       period_c = '0;
    logic [mjos_pkg::PERIOD_W-1:0]       period_d = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [mjos_pkg::JITTER_OUT_W-1:0]   min_jitter;
    logic [mjos_pkg::OFFSET_W-1:0]       best_offset_b;
    logic [mjos_pkg::OFFSET_W-1:0]       best_offset_c;
    logic [mjos_pkg::OFFSET_W-1:0]       best_offset_d;

    schedule_checker sb = new();
    int unsigned     send_idle = 32;
    int unsigned     recv_idle = 71;
    longint unsigned cycle_count = 0;
    longint unsigned cycle_budget = 40000;

    min_jitter_offset_search_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .period_a      (period_a),
        .period_b      (period_b),
        .period_c      (period_c),
        .period_d      (period_d),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .min_jitter    (min_jitter),
        .best_offset_b (best_offset_b),
        .best_offset_c (best_offset_c),
        .best_offset_d (best_offset_d)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_budget)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word('{min_jitter, best_offset_b, best_offset_c, best_offset_d});
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic send_word(input logic [mjos_pkg::PERIOD_W-1:0] pa,
                             input logic [mjos_pkg::PERIOD_W-1:0] pb,
                             input logic [mjos_pkg::PERIOD_W-1:0] pc,
                             input logic [mjos_pkg::PERIOD_W-1:0] pd);
        int unsigned cost;
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        in_valid <= 1'b1;
        period_a <= pa;
        period_b <= pb;
        period_c <= pc;
        period_d <= pd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cost = sb.note_word(pa, pb, pc, pd);
        cycle_budget += 4 * longint'(cost) + 2000;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_frame(input logic [mjos_pkg::PERIOD_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_frame(value);
    endtask

    // mostly short periods, sometimes the full 9-bit range
    function automatic logic [mjos_pkg::PERIOD_W-1:0] rand_period();
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 9);
        if (r < 6)
            v = $urandom_range(1, 7);
        else if (r < 9)
            v = $urandom_range(0, 511);
        else
            v = 0;
        return v[mjos_pkg::PERIOD_W-1:0];
    endfunction

    initial
    begin
        int unsigned frame_pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame size
        send_word(200, 2, 2, 2);
        send_word(0, 0, 3, 3);
        send_word(10, 3, 0, 1);
        send_word(10, 5, 5, 0);
        // empty frame
        write_frame(0);
        send_word(1, 1, 1, 1);
        send_word(511, 511, 511, 511);
        send_word(0, 256, 256, 256);
        // single slot, periods above 256
        write_frame(1);
        send_word(0, 1, 1, 1);
        send_word(511, 300, 257, 256);
        send_word(256, 256, 256, 256);
        // full frame
        write_frame(256);
        send_word(0, 2, 2, 2);
        send_word(128, 2, 3, 4);
        // saturated frame
        write_frame(511);
        send_word(0, 2, 2, 2);
        send_word(255, 3, 4, 5);
        write_frame(4);
        send_word(1, 1, 1, 1);
        send_word(2, 4, 3, 2);
        send_word(3, 5, 7, 6);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 32 : (mode == 1) ? 71 : 0;
            recv_idle = (mode == 0) ? 71 : (mode == 1) ? 32 : 0;
            for (int phase = 0; phase < 3; phase++)
            begin
                frame_pick = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                write_frame(frame_pick[mjos_pkg::PERIOD_W-1:0]);
                for (int n = 0; n < 9; n++)
                begin
                    if (mode == 1 && phase == 1 && n == 6)
                        wait_drained();
                    send_word(rand_period(), rand_period(), rand_period(), rand_period());
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
